// File: rtl/core/bchd_pkg.sv
// Package for the button click/hold detector: event codes, register
// indexes, payload and configuration structs. No dependencies.
package bchd_pkg;

    localparam int CfgIdxW    = 2;
    localparam int CfgDataW   = 16;
    localparam int DebW       = 8;
    localparam int TimeW      = 16;
    localparam int StampW     = 32;
    localparam int ClickW     = 2;

    localparam logic [ClickW-1:0] MaxClicks = ClickW'(2);

    localparam logic [CfgIdxW-1:0] RegDebounceTicks = CfgIdxW'(0);
    localparam logic [CfgIdxW-1:0] RegHoldTime      = CfgIdxW'(1);
    localparam logic [CfgIdxW-1:0] RegClickWindow   = CfgIdxW'(2);

    localparam logic [DebW-1:0]  DebounceTicksRst = DebW'(20);
    localparam logic [TimeW-1:0] HoldTimeRst      = TimeW'(1000);
    localparam logic [TimeW-1:0] ClickWindowRst   = TimeW'(300);

    typedef enum logic [2:0] {
        EV_NONE       = 3'd0,
        EV_SINGLE     = 3'd1,
        EV_DOUBLE     = 3'd2,
        EV_HOLD_START = 3'd3,
        EV_HOLD_END   = 3'd4
    } t_event;

    typedef struct packed {
        logic              raw_level;
        logic [StampW-1:0] now_ms;
        logic              take_event;
    } t_in;

    typedef struct packed {
        t_event event_code;
        logic   stable_level;
    } t_out;

    typedef struct packed {
        logic [DebW-1:0]  debounce_ticks;
        logic [TimeW-1:0] hold_time;
        logic [TimeW-1:0] click_window;
    } t_cfg;

    typedef struct packed {
        logic              stable;
        logic              holding;
        logic [ClickW-1:0] clicks;
    } t_status;

endpackage

// File: rtl/core/button_click_hold_detector.sv
// Top level of the button click/hold detector: input register, per-tick
// update core, output register and configuration registers. Depends on
// bchd_pkg, bchd_cfg and bchd_core.
//
//  channel   direction  signals                                  payload
//  --------  ---------  ---------------------------------------  -------------
//  tick in   in         i_in_valid, o_in_stall, i_in_data         bchd_pkg::t_in
//  event out out        o_out_valid, i_out_stall, o_out_data      bchd_pkg::t_out
//  config    in         i_cfg_we, i_cfg_idx, i_cfg_data           16-bit write
//
// One tick per cycle sustained while the output is not stalled. A tick
// transfer lands in the input register; the core then updates its state and
// the result lands in the output register, so o_out_valid rises once the
// result is registered and the result transfer is made from that register.
// Reset (i_rst_n low, synchronous) clears all state and restores register
// defaults. A stall on the output holds the result register; the input
// register then fills and o_in_stall rises in the same cycle, so no tick is
// dropped and none is processed twice.
module button_click_hold_detector (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  bchd_pkg::t_in                 i_in_data,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output bchd_pkg::t_out                o_out_data,
    input  logic                          i_cfg_we,
    input  logic [bchd_pkg::CfgIdxW-1:0]  i_cfg_idx,
    input  logic [bchd_pkg::CfgDataW-1:0] i_cfg_data
);

    logic               r_in_valid;
    bchd_pkg::t_in      r_in_data;
    logic               r_out_valid;
    bchd_pkg::t_out     r_out_data;

    bchd_pkg::t_cfg     cfg;
    bchd_pkg::t_out     result;
    bchd_pkg::t_status  status;

    logic               out_free;
    logic               fire;
    logic               in_take;

    // output register can take a new result when empty or being drained
    assign out_free   = !r_out_valid || !i_out_stall;
    assign fire       = r_in_valid && out_free;
    assign o_in_stall = r_in_valid && !out_free;
    assign in_take    = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (fire) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_data <= i_in_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= fire;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out_data <= result;
        end
    end

    bchd_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    bchd_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (fire),
        .i_item   (r_in_data),
        .i_cfg    (cfg),
        .o_result (result),
        .o_status (status)
    );

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    // a hold only exists while the debounced level is pressed
    a_hold_pressed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        status.holding |-> status.stable)
        else $error("hold active while released");

    // a hold drops any pending clicks
    a_hold_no_clicks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        status.holding |-> (status.clicks == '0))
        else $error("clicks pending during hold");

    // click count saturates at two
    a_click_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        status.clicks <= bchd_pkg::MaxClicks)
        else $error("click count beyond saturation");

    // input backpressure only when both registers are full and output stalled
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_in_valid && o_out_valid && i_out_stall))
        else $error("input stalled without full pipeline");

endmodule

// File: rtl/core/bchd_cfg.sv
// Configuration register file for the detector: three write-only registers.
// Depends on bchd_pkg.
module bchd_cfg (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [bchd_pkg::CfgIdxW-1:0]   i_cfg_idx,
    input  logic [bchd_pkg::CfgDataW-1:0]  i_cfg_data,
    output bchd_pkg::t_cfg                 o_cfg
);

    bchd_pkg::t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.debounce_ticks <= bchd_pkg::DebounceTicksRst;
            r_cfg.hold_time      <= bchd_pkg::HoldTimeRst;
            r_cfg.click_window   <= bchd_pkg::ClickWindowRst;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                bchd_pkg::RegDebounceTicks:
                    r_cfg.debounce_ticks <= i_cfg_data[bchd_pkg::DebW-1:0];
                bchd_pkg::RegHoldTime:
                    r_cfg.hold_time <= i_cfg_data[bchd_pkg::TimeW-1:0];
                bchd_pkg::RegClickWindow:
                    r_cfg.click_window <= i_cfg_data[bchd_pkg::TimeW-1:0];
                default: begin
                    // index beyond the list: ignored
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// File: rtl/core/bchd_core.sv
// Per-tick update of the detector state: debounce, press/hold tracking,
// click window and event latch. Depends on bchd_pkg.
module bchd_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_fire,
    input  bchd_pkg::t_in     i_item,
    input  bchd_pkg::t_cfg    i_cfg,
    output bchd_pkg::t_out    o_result,
    output bchd_pkg::t_status o_status
);

    logic                                r_stable;
    logic                                r_prev;
    logic                                r_holding;
    logic [bchd_pkg::ClickW-1:0]         r_clicks;
    logic [bchd_pkg::DebW-1:0]           r_deb_cnt;
    logic [bchd_pkg::TimeW-1:0]          r_win_cnt;
    logic [bchd_pkg::StampW-1:0]         r_press_time;
    bchd_pkg::t_event                    r_event;

    logic                                n_stable;
    logic                                n_prev;
    logic                                n_holding;
    logic [bchd_pkg::ClickW-1:0]         n_clicks;
    logic [bchd_pkg::DebW-1:0]           n_deb_cnt;
    logic [bchd_pkg::TimeW-1:0]          n_win_cnt;
    logic [bchd_pkg::StampW-1:0]         n_press_time;
    bchd_pkg::t_event                    n_event;
    bchd_pkg::t_event                    rpt_event;

    logic [bchd_pkg::DebW-1:0]           deb_inc;
    logic [bchd_pkg::TimeW-1:0]          win_inc;
    logic [bchd_pkg::StampW-1:0]         elapsed;

    always_comb begin
        n_stable     = r_stable;
        n_holding    = r_holding;
        n_clicks     = r_clicks;
        n_deb_cnt    = r_deb_cnt;
        n_win_cnt    = r_win_cnt;
        n_press_time = r_press_time;
        rpt_event    = r_event;
        deb_inc      = r_deb_cnt + bchd_pkg::DebW'(1);
        win_inc      = r_win_cnt + bchd_pkg::TimeW'(1);

        // debounce
        if (i_item.raw_level != r_stable) begin
            if (deb_inc >= i_cfg.debounce_ticks) begin
                n_stable  = i_item.raw_level;
                n_deb_cnt = '0;
            end else begin
                n_deb_cnt = deb_inc;
            end
        end else begin
            n_deb_cnt = '0;
        end

        // stable rising edge
        if (n_stable && !r_prev) begin
            n_press_time = i_item.now_ms;
            if (!r_holding && (r_clicks < bchd_pkg::MaxClicks)) begin
                n_clicks = r_clicks + bchd_pkg::ClickW'(1);
            end
        end

        // hold check, elapsed time wraps modulo 2^32
        elapsed = i_item.now_ms - n_press_time;
        if (n_stable && !r_holding &&
            (elapsed >= {{(bchd_pkg::StampW-bchd_pkg::TimeW){1'b0}}, i_cfg.hold_time})) begin
            n_holding = 1'b1;
            n_clicks  = '0;
            rpt_event = bchd_pkg::EV_HOLD_START;
        end

        // stable falling edge
        if (!n_stable && r_prev) begin
            if (r_holding) begin
                rpt_event = bchd_pkg::EV_HOLD_END;
                n_holding = 1'b0;
            end
            n_press_time = '0;
        end

        // click window, runs only while released with clicks pending
        if (!n_holding && !n_stable && (n_clicks != '0)) begin
            n_win_cnt = win_inc;
            if (win_inc >= i_cfg.click_window) begin
                if (n_clicks == bchd_pkg::ClickW'(1)) begin
                    rpt_event = bchd_pkg::EV_SINGLE;
                end else if (n_clicks == bchd_pkg::MaxClicks) begin
                    rpt_event = bchd_pkg::EV_DOUBLE;
                end
                n_clicks  = '0;
                n_win_cnt = '0;
            end
        end

        n_prev  = n_stable;
        n_event = i_item.take_event ? bchd_pkg::EV_NONE : rpt_event;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stable     <= 1'b0;
            r_prev       <= 1'b0;
            r_holding    <= 1'b0;
            r_clicks     <= '0;
            r_deb_cnt    <= '0;
            r_win_cnt    <= '0;
            r_press_time <= '0;
            r_event      <= bchd_pkg::EV_NONE;
        end else if (i_fire) begin
            r_stable     <= n_stable;
            r_prev       <= n_prev;
            r_holding    <= n_holding;
            r_clicks     <= n_clicks;
            r_deb_cnt    <= n_deb_cnt;
            r_win_cnt    <= n_win_cnt;
            r_press_time <= n_press_time;
            r_event      <= n_event;
        end
    end

    assign o_result.event_code   = rpt_event;
    assign o_result.stable_level = n_stable;

    assign o_status.stable  = r_stable;
    assign o_status.holding = r_holding;
    assign o_status.clicks  = r_clicks;

endmodule

// File: dv/bchd_event_checker.sv
// Scoreboard for the button click/hold detector: watches the tick, event and
// register-write ports, predicts each report and compares. Depends on bchd_pkg.
module bchd_event_checker
    import bchd_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                i_in_stall,
    input  t_in                 i_in_data,
    input  logic                i_out_valid,
    input  logic                i_out_stall,
    input  t_out                i_out_data,
    input  logic                i_cfg_we,
    input  logic [CfgIdxW-1:0]  i_cfg_idx,
    input  logic [CfgDataW-1:0] i_cfg_data,
    output int                  o_fail_count,
    output int                  o_pending,
    output int                  o_checked,
    output logic [7:0]          o_events_seen
);

    // register copies
    logic [DebW-1:0]   deb_ticks;
    logic [TimeW-1:0]  hold_ms;
    logic [TimeW-1:0]  window_ticks;

    // detector state
    logic              stable;
    logic              prev_stable;
    logic              holding;
    logic [ClickW-1:0] clicks;
    logic [DebW-1:0]   deb_count;
    logic [TimeW-1:0]  win_count;
    logic [StampW-1:0] press_stamp;
    t_event            latched;

    t_out              expected_reports[$];
    int                failures = 0;
    int                checked = 0;
    logic [7:0]        seen = '0;

    // one tick of the detector; report is taken before the read-clear
    task automatic predict_tick(input t_in tick, output t_out report);
        logic [StampW-1:0] elapsed;
        if (tick.raw_level != stable) begin
            deb_count = deb_count + 1'b1;
            if (deb_count >= deb_ticks) begin
                stable    = tick.raw_level;
                deb_count = '0;
            end
        end else begin
            deb_count = '0;
        end

        if (stable && !prev_stable) begin
            press_stamp = tick.now_ms;
            if (!holding && clicks < MaxClicks)
                clicks = clicks + 1'b1;
        end

        elapsed = tick.now_ms - press_stamp;
        if (stable && !holding && elapsed >= StampW'(hold_ms)) begin
            holding = 1'b1;
            clicks  = '0;
            latched = EV_HOLD_START;
        end

        if (!stable && prev_stable) begin
            if (holding) begin
                latched = EV_HOLD_END;
                holding = 1'b0;
            end
            press_stamp = '0;
        end

        // window keeps counting across presses, restarts only on an event
        if (!holding && !stable && clicks != '0) begin
            win_count = win_count + 1'b1;
            if (win_count >= window_ticks) begin
                if (clicks == ClickW'(1))
                    latched = EV_SINGLE;
                else if (clicks == MaxClicks)
                    latched = EV_DOUBLE;
                clicks    = '0;
                win_count = '0;
            end
        end

        prev_stable         = stable;
        report.event_code   = latched;
        report.stable_level = stable;
        if (tick.take_event)
            latched = EV_NONE;
    endtask

    always @(posedge i_clk) begin
        t_out due;
        t_out fresh;
        if (!i_rst_n) begin
            deb_ticks    = DebounceTicksRst;
            hold_ms      = HoldTimeRst;
            window_ticks = ClickWindowRst;
            stable       = 1'b0;
            prev_stable  = 1'b0;
            holding      = 1'b0;
            clicks       = '0;
            deb_count    = '0;
            win_count    = '0;
            press_stamp  = '0;
            latched      = EV_NONE;
            expected_reports.delete();
        end else begin
            // compare first: a result transfer always belongs to an older tick
            if (i_out_valid && !i_out_stall) begin
                checked++;
                seen[i_out_data.event_code] = 1'b1;
                if (expected_reports.size() == 0) begin
                    failures++;
                    $display("%0t: unexpected result, event_code %0d stable_level %0b",
                             $time, i_out_data.event_code, i_out_data.stable_level);
                end else begin
                    due = expected_reports.pop_front();
                    if (due.event_code !== i_out_data.event_code) begin
                        failures++;
                        $display("%0t: event_code expected %0d got %0d",
                                 $time, due.event_code, i_out_data.event_code);
                    end
                    if (due.stable_level !== i_out_data.stable_level) begin
                        failures++;
                        $display("%0t: stable_level expected %0b got %0b",
                                 $time, due.stable_level, i_out_data.stable_level);
                    end
                end
            end

            if (i_cfg_we) begin
                case (i_cfg_idx)
                    RegDebounceTicks: deb_ticks    = i_cfg_data[DebW-1:0];
                    RegHoldTime:      hold_ms      = i_cfg_data[TimeW-1:0];
                    RegClickWindow:   window_ticks = i_cfg_data[TimeW-1:0];
                    default: ;
                endcase
            end

            if (i_in_valid && !i_in_stall) begin
                predict_tick(i_in_data, fresh);
                expected_reports.push_back(fresh);
            end
        end
        o_fail_count  <= failures;
        o_pending     <= expected_reports.size();
        o_checked     <= checked;
        o_events_seen <= seen;
    end

endmodule

// File: dv/button_click_hold_detector_test.sv
// Testbench top for the button click/hold detector: clock, reset, tick and
// register stimulus, random stalls and the verdict. Depends on bchd_pkg,
// button_click_hold_detector and bchd_event_checker.
module button_click_hold_detector_test;
    import bchd_pkg::*;

    localparam int TickLimit   = 200000;  // cycles before the watchdog fires
    localparam int PhaseTicks  = 128;     // ticks per random register setting
    localparam int Phases      = 12;
    localparam int CalmPhases  = 2;       // trailing phases run without idling
    localparam int WidePhase   = 4;       // phase that uses the widest settings
    localparam int WideTicks   = 40;
    localparam int DrainCycles = 8;       // plenty of margin after the final drain

    // index past the register list; the block must ignore it
    localparam logic [CfgIdxW-1:0] RegSpare = CfgIdxW'(3);

    logic                clk;
    logic                rst_n    = 1'b0;
    logic                in_valid = 1'b0;
    logic                in_stall;
    t_in                 in_data  = '0;
    logic                out_valid;
    logic                out_stall = 1'b0;
    t_out                out_data;
    logic                cfg_we   = 1'b0;
    logic [CfgIdxW-1:0]  cfg_idx  = '0;
    logic [CfgDataW-1:0] cfg_data = '0;

    int                  fail_count;
    int                  pending;
    int                  checked;
    logic [7:0]          events_seen;

    bit                  calm = 1'b0;     // set: no sender gaps, no sink stalls
    int                  ticks_sent = 0;
    int                  settings_used = 0;
    int                  cycle_count = 0;
    logic [StampW-1:0]   stamp;           // running millisecond clock

    button_click_hold_detector DUT (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .o_in_stall   (in_stall),
        .i_in_data    (in_data),
        .o_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .o_out_data   (out_data),
        .i_cfg_we     (cfg_we),
        .i_cfg_idx    (cfg_idx),
        .i_cfg_data   (cfg_data)
    );

    bchd_event_checker u_checker (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_in_valid    (in_valid),
        .i_in_stall    (in_stall),
        .i_in_data     (in_data),
        .i_out_valid   (out_valid),
        .i_out_stall   (out_stall),
        .i_out_data    (out_data),
        .i_cfg_we      (cfg_we),
        .i_cfg_idx     (cfg_idx),
        .i_cfg_data    (cfg_data),
        .o_fail_count  (fail_count),
        .o_pending     (pending),
        .o_checked     (checked),
        .o_events_seen (events_seen)
    );

    initial begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // watchdog: a hang or a lost result ends here
    initial begin : watchdog
        while (cycle_count < TickLimit) begin
            @(posedge clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles, %0d results still due", cycle_count, pending);
        $display("simulation failed");
        $finish;
    end

    // sink side: random stall bursts, now and then a long quiet stretch;
    // stops stalling once the run turns calm
    initial begin : sink_stall
        @(posedge clk);
        forever begin
            if (!calm && $urandom_range(0, 3) == 0) begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 3)) @(posedge clk);
                out_stall <= 1'b0;
            end else if ($urandom_range(0, 15) == 0) begin
                repeat ($urandom_range(20, 60)) @(posedge clk);
            end
            @(posedge clk);
        end
    end

    // one tick transfer; valid stays high afterwards so back-to-back ticks
    // go out without a bubble
    task automatic send_tick(input logic raw, input logic [StampW-1:0] now,
                             input logic take);
        if (!calm && $urandom_range(0, 5) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= t_in'{raw_level: raw, now_ms: now, take_event: take};
        @(posedge clk);
        while (in_stall) @(posedge clk);
        ticks_sent++;
    endtask

    // hold the sender until every predicted report has been seen; the first
    // edge lets the checker count the last transfer
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
    endtask

    // registers only change with the block idle
    task automatic set_config(input logic [CfgDataW-1:0] deb_word,
                              input logic [TimeW-1:0] hold,
                              input logic [TimeW-1:0] window,
                              input bit poke_spare);
        drain();
        cfg_we   <= 1'b1;
        cfg_idx  <= RegDebounceTicks;
        cfg_data <= deb_word;
        @(posedge clk);
        cfg_idx  <= RegHoldTime;
        cfg_data <= hold;
        @(posedge clk);
        cfg_idx  <= RegClickWindow;
        cfg_data <= window;
        @(posedge clk);
        if (poke_spare) begin
            cfg_idx  <= RegSpare;
            cfg_data <= CfgDataW'($urandom);
            @(posedge clk);
        end
        cfg_we <= 1'b0;
        settings_used++;
    endtask

    // press/release episodes with contact bounce, random reads and rare
    // timestamp jumps; one in ten episodes is pure pin noise
    task automatic run_phase(input int budget);
        int   count;
        int   run_len;
        bit   noise;
        logic raw;
        count = 0;
        stamp = StampW'($urandom);
        while (count < budget) begin
            noise = ($urandom_range(0, 9) == 0);
            for (int seg = 0; seg < 2 && count < budget; seg++) begin
                run_len = (seg == 0) ? $urandom_range(1, 48) : $urandom_range(1, 32);
                for (int k = 0; k < run_len && count < budget; k++) begin
                    raw = noise ? 1'($urandom_range(0, 1)) : (seg == 0);
                    if (!noise && $urandom_range(0, 7) == 0)
                        raw = !raw;  // bounce
                    if ($urandom_range(0, 63) == 0)
                        stamp = StampW'($urandom);
                    else
                        stamp = stamp + $urandom_range(0, 3);
                    send_tick(raw, stamp, $urandom_range(0, 3) == 0);
                    count++;
                end
            end
        end
    endtask

    initial begin : stimulus
        logic [DebW-1:0]  deb;
        logic [TimeW-1:0] hold;
        logic [TimeW-1:0] window;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // reset defaults: one press tick is far below the debounce count
        send_tick(1'b1, 32'd0, 1'b0);

        // no debounce, no hold time: hold starts on the press tick, stamps at
        // both ends of the range
        set_config(16'h0000, 16'h0000, 16'h0000, 1'b0);
        send_tick(1'b1, 32'hFFFF_FFFF, 1'b0);
        send_tick(1'b1, 32'h0000_0000, 1'b1);
        send_tick(1'b0, 32'h8000_0000, 1'b0);
        send_tick(1'b0, 32'h7FFF_FFFF, 1'b1);

        // zero window with a click pending: event on the first released tick
        set_config(16'h0000, 16'd100, 16'h0000, 1'b0);
        send_tick(1'b1, 32'd40, 1'b0);
        send_tick(1'b0, 32'd41, 1'b1);

        // debounce word with junk in the upper byte, spare index written;
        // three presses in one window saturate at a double click
        set_config(16'hAB01, 16'd50, 16'd3, 1'b1);
        send_tick(1'b1, 32'd20, 1'b0);
        send_tick(1'b0, 32'd21, 1'b0);
        send_tick(1'b1, 32'd22, 1'b0);
        send_tick(1'b0, 32'd23, 1'b0);
        send_tick(1'b1, 32'd24, 1'b0);
        send_tick(1'b0, 32'd25, 1'b0);
        send_tick(1'b0, 32'd26, 1'b1);
        // lone press runs out the window as a single click
        send_tick(1'b1, 32'd27, 1'b0);
        send_tick(1'b0, 32'd28, 1'b0);
        send_tick(1'b0, 32'd29, 1'b0);
        send_tick(1'b0, 32'd30, 1'b0);
        send_tick(1'b0, 32'd31, 1'b1);
        // timestamp steps back: looks like a long press, then hold end
        // overwrites the unread hold start
        send_tick(1'b1, 32'd1000, 1'b0);
        send_tick(1'b1, 32'd999, 1'b0);
        send_tick(1'b0, 32'd1000, 1'b0);

        for (int phase = 0; phase < Phases; phase++) begin
            if (phase == WidePhase) begin
                set_config(16'h00FF, 16'hFFFF, 16'hFFFF, 1'b0);
            end else begin
                deb    = DebW'($urandom_range(0, 4));
                hold   = TimeW'($urandom_range(0, 40));
                window = TimeW'($urandom_range(0, 24));
                set_config({8'($urandom), deb}, hold, window, $urandom_range(0, 3) == 0);
            end
            if (phase >= Phases - CalmPhases)
                calm = 1'b1;
            run_phase(phase == WidePhase ? WideTicks : PhaseTicks);
        end

        drain();
        repeat (DrainCycles) @(posedge clk);

        $display("covered %0d ticks under %0d register settings, %0d reports checked",
                 ticks_sent, settings_used, checked);
        $display("event codes reported, one bit per code from none upward: %b",
                 events_seen[4:0]);
        if (fail_count == 0 && pending == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

// File: filelist.f
rtl/core/bchd_pkg.sv
rtl/core/bchd_cfg.sv
rtl/core/bchd_core.sv
rtl/core/button_click_hold_detector.sv
dv/bchd_event_checker.sv
dv/button_click_hold_detector_test.sv
